FILE: src/assert_macros.svh
// assertion macros shared by the hsv to rgb converter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// trigger at one edge implies the condition at the next edge
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cond, msg)

`endif

`endif

FILE: src/hsvrgb_pkg.sv
// types and constants of the hsv to rgb converter with dimming curve
`timescale 1ns / 1ps

package hsvrgb_pkg;

  // curve table geometry
  localparam int CURVE_W     = 8;
  localparam int CURVE_DEPTH = 256;

  // default depth of the queue between front and back
  localparam int Q_DEPTH = 4;

  // hue handling
  localparam logic [8:0] FULL_CIRCLE = 9'd360;
  localparam logic [8:0] SECTOR_SPAN = 9'd60;
  localparam logic [5:0] SPAN_60     = 6'd60;

  // x / 60 as (x * RECIP_60) >> RECIP_SHIFT, exact for x below 2^14
  localparam logic [14:0] RECIP_60    = 15'd17477;
  localparam int          RECIP_SHIFT = 20;

  // curve entry that marks zero saturation
  localparam logic [7:0] FULL_SCALE = 8'hFF;

  // item kinds
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_CURVE = 1'b1
  } kind_t;

  // hue sectors, named after the channel pattern
  typedef enum logic [2:0] {
    SEC_R_GUP  = 3'd0,
    SEC_RDN_G  = 3'd1,
    SEC_G_BUP  = 3'd2,
    SEC_GDN_B  = 3'd3,
    SEC_B_RUP  = 3'd4,
    SEC_BDN_R  = 3'd5
  } sector_t;

  // input item
  typedef struct packed {
    kind_t      kind;
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
    logic [7:0] curve_index;
    logic [7:0] curve_data;
  } pix_in_t;

  // result item
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_out_t;

  // classified pixel between front and back
  typedef struct packed {
    sector_t    sector;
    logic [5:0] rem;
    logic [7:0] val;
    logic [7:0] cs;
  } q_entry_t;

  // queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

FILE: src/hsvrgb_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module hsvrgb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/hsvrgb_front.sv
// front end: accepts items, writes or reads the curve, classifies hue
`timescale 1ns / 1ps

module hsvrgb_front import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_in_t  in_data,
  output logic     push,
  output q_entry_t push_data,
  input  q_stat_t  q_stat,
  output logic     busy
);

  logic       accept;
  logic       wr_en;
  logic       rd_en;
  logic [8:0] hue_w;
  sector_t    sector_c;
  logic [5:0] rem_c;
  logic       s1_valid_r, s1_valid_nxt;
  sector_t    s1_sector_r;
  logic [5:0] s1_rem_r;
  logic [7:0] val_rd;
  logic [7:0] cs_rd;

  // handshake
  assign in_ready = !s1_valid_r || !q_stat.full;
  assign accept   = in_valid && in_ready;
  assign push     = s1_valid_r && !q_stat.full;
  assign wr_en    = accept && (in_data.kind == KIND_CURVE);
  assign rd_en    = accept && (in_data.kind == KIND_PIXEL);
  assign busy     = s1_valid_r;

  // hue wrap and sector split
  always_comb begin
    if (in_data.hue >= FULL_CIRCLE) begin
      hue_w = in_data.hue - FULL_CIRCLE;
    end else begin
      hue_w = in_data.hue;
    end
    priority if (hue_w < SECTOR_SPAN) begin
      sector_c = SEC_R_GUP;
      rem_c    = hue_w[5:0];
    end else if (hue_w < 9'(2 * SECTOR_SPAN)) begin
      sector_c = SEC_RDN_G;
      rem_c    = 6'(hue_w - SECTOR_SPAN);
    end else if (hue_w < 9'(3 * SECTOR_SPAN)) begin
      sector_c = SEC_G_BUP;
      rem_c    = 6'(hue_w - 9'(2 * SECTOR_SPAN));
    end else if (hue_w < 9'(4 * SECTOR_SPAN)) begin
      sector_c = SEC_GDN_B;
      rem_c    = 6'(hue_w - 9'(3 * SECTOR_SPAN));
    end else if (hue_w < 9'(5 * SECTOR_SPAN)) begin
      sector_c = SEC_B_RUP;
      rem_c    = 6'(hue_w - 9'(4 * SECTOR_SPAN));
    end else begin
      sector_c = SEC_BDN_R;
      rem_c    = 6'(hue_w - 9'(5 * SECTOR_SPAN));
    end
  end

  // curve copy read by brightness
  hsvrgb_ram #(
    .WIDTH (CURVE_W),
    .DEPTH (CURVE_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_data.curve_index),
    .wdata (in_data.curve_data),
    .re    (rd_en),
    .raddr (in_data.brightness),
    .rdata (val_rd)
  );

  // curve copy read by inverted saturation
  hsvrgb_ram #(
    .WIDTH (CURVE_W),
    .DEPTH (CURVE_DEPTH)
  ) u_sat_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (in_data.curve_index),
    .wdata (in_data.curve_data),
    .re    (rd_en),
    .raddr (~in_data.saturation),
    .rdata (cs_rd)
  );

  // lookup stage valid
  always_comb begin
    if (rd_en) begin
      s1_valid_nxt = 1'b1;
    end else if (push) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // sector info travels next to the ram read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_sector_r <= sector_c;
      s1_rem_r    <= rem_c;
    end
  end

  assign push_data = '{sector: s1_sector_r, rem: s1_rem_r, val: val_rd, cs: cs_rd};

endmodule

FILE: src/hsvrgb_fifo.sv
// small register queue between front and back
`timescale 1ns / 1ps

module hsvrgb_fifo import hsvrgb_pkg::*; #(
  parameter int DEPTH = Q_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_data,
  input  logic     pop,
  output q_entry_t pop_data,
  output q_stat_t  q_stat
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        store_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data     = store_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

FILE: src/hsvrgb_back.sv
// back end: base level, sector ramps and channel select
`timescale 1ns / 1ps

module hsvrgb_back import hsvrgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  output logic     q_ready,
  input  q_entry_t q_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rgb_out_t out_data
);

  // stage valids and readies
  logic v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt, vo_r, vo_nxt;
  logic ready1, ready2, ready3, ready_o;
  logic load1, load2, load3, load_o;

  // stage 1: base level
  logic [15:0] base_prod;
  logic [7:0]  base1_r, val1_r;
  logic [5:0]  rem1_r;
  sector_t     sec1_r;
  logic        gray1_r;

  // stage 2: ramp products
  logic [7:0]  diff;
  logic [13:0] up_prod, dn_prod;
  logic [13:0] mul_up2_r, mul_dn2_r;
  logic [7:0]  base2_r, val2_r;
  sector_t     sec2_r;
  logic        gray2_r;

  // stage 3: divide by 60
  logic [28:0] up_recip, dn_recip;
  logic [7:0]  q_up3_r, q_dn3_r, base3_r, val3_r;
  sector_t     sec3_r;
  logic        gray3_r;

  // output stage
  logic [7:0]  up_lvl, dn_lvl;
  rgb_out_t    rgb_c;
  rgb_out_t    out_data_r;

  assign ready_o = !vo_r || out_ready;
  assign ready3  = !v3_r || ready_o;
  assign ready2  = !v2_r || ready3;
  assign ready1  = !v1_r || ready2;

  assign load1  = q_valid && ready1;
  assign load2  = v1_r && ready2;
  assign load3  = v2_r && ready3;
  assign load_o = v3_r && ready_o;

  assign q_ready = ready1;

  assign v1_nxt = load1  || (v1_r && !ready2);
  assign v2_nxt = load2  || (v2_r && !ready3);
  assign v3_nxt = load3  || (v3_r && !ready_o);
  assign vo_nxt = load_o || (vo_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      vo_r <= vo_nxt;
    end
  end

  // base = (255 - sat) * val >> 8, and 255 - sat is the curve entry itself
  assign base_prod = 16'(q_data.val) * 16'(q_data.cs);

  always_ff @(posedge clk) begin
    if (load1) begin
      base1_r <= base_prod[15:8];
      val1_r  <= q_data.val;
      rem1_r  <= q_data.rem;
      sec1_r  <= q_data.sector;
      gray1_r <= (q_data.cs == FULL_SCALE);
    end
  end

  // rising and falling ramp products
  assign diff    = val1_r - base1_r;
  assign up_prod = 14'(diff) * 14'(rem1_r);
  assign dn_prod = 14'(diff) * 14'(SPAN_60 - rem1_r);

  always_ff @(posedge clk) begin
    if (load2) begin
      mul_up2_r <= up_prod;
      mul_dn2_r <= dn_prod;
      base2_r   <= base1_r;
      val2_r    <= val1_r;
      sec2_r    <= sec1_r;
      gray2_r   <= gray1_r;
    end
  end

  // truncating divide by 60 through the reciprocal
  assign up_recip = 29'(mul_up2_r) * 29'(RECIP_60);
  assign dn_recip = 29'(mul_dn2_r) * 29'(RECIP_60);

  always_ff @(posedge clk) begin
    if (load3) begin
      q_up3_r <= up_recip[RECIP_SHIFT +: 8];
      q_dn3_r <= dn_recip[RECIP_SHIFT +: 8];
      base3_r <= base2_r;
      val3_r  <= val2_r;
      sec3_r  <= sec2_r;
      gray3_r <= gray2_r;
    end
  end

  // channel pattern per sector
  assign up_lvl = q_up3_r + base3_r;
  assign dn_lvl = q_dn3_r + base3_r;

  always_comb begin
    if (gray3_r) begin
      rgb_c = '{red: val3_r, green: val3_r, blue: val3_r};
    end else begin
      unique case (sec3_r)
        SEC_R_GUP: rgb_c = '{red: val3_r,  green: up_lvl,  blue: base3_r};
        SEC_RDN_G: rgb_c = '{red: dn_lvl,  green: val3_r,  blue: base3_r};
        SEC_G_BUP: rgb_c = '{red: base3_r, green: val3_r,  blue: up_lvl};
        SEC_GDN_B: rgb_c = '{red: base3_r, green: dn_lvl,  blue: val3_r};
        SEC_B_RUP: rgb_c = '{red: up_lvl,  green: base3_r, blue: val3_r};
        default:   rgb_c = '{red: val3_r,  green: base3_r, blue: dn_lvl};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load_o) begin
      out_data_r <= rgb_c;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_data_r;

endmodule

FILE: src/hsv_to_rgb_with_dim_curve.sv
// hsv to rgb converter with a loadable dimming curve, top level
// a pixel item passes the curve ram read at accept, then the queue, base multiply,
// ramp multiply, divide by 60 and select registers before out_valid
// throughput: one item per cycle unless out_ready stalls, set by the single ram port pair
// and the pipelined back end; curve write items give no result
// reset (rst_n, sync) clears valids and queue pointers; curve ram holds garbage until written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hsv_to_rgb_with_dim_curve import hsvrgb_pkg::*; #(
  parameter int QUEUE_DEPTH = Q_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pix_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rgb_out_t out_data
);

  logic     push;
  logic     pop;
  logic     q_ready;
  logic     front_busy;
  logic     acc_curve;
  logic     acc_pixel;
  q_entry_t push_data;
  q_entry_t pop_data;
  q_stat_t  q_stat;

  // accept, curve access and hue classification
  hsvrgb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .push      (push),
    .push_data (push_data),
    .q_stat    (q_stat),
    .busy      (front_busy)
  );

  // decoupling queue
  assign pop = !q_stat.empty && q_ready;

  hsvrgb_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  // color arithmetic
  hsvrgb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (!q_stat.empty),
    .q_ready   (q_ready),
    .q_data    (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // accepted item kinds
  assign acc_curve = in_valid && in_ready && (in_data.kind == KIND_CURVE);
  assign acc_pixel = in_valid && in_ready && (in_data.kind == KIND_PIXEL);

  // queue status is consistent
  `ASSERT_ALWAYS(a_q_stat, clk, rst_n, !(q_stat.full && q_stat.empty), "queue full and empty")

  // a curve write leaves the lookup stage empty
  `ASSERT_NEXT(a_curve_no_item, clk, rst_n, acc_curve, !front_busy, "curve write made an item")

  // a pixel item always reaches the lookup stage
  `ASSERT_NEXT(a_pixel_item, clk, rst_n, acc_pixel, front_busy, "pixel item lost at lookup")

endmodule
